// File: rtl/cdq_pkg.sv
// Shared types and codes for the circular double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    // Operation codes carried on the func field
    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_BACK  = 3'd5
    } func_t;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Data word returned for pushes, refusals and unused codes
    localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } cdq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } cdq_stat_t;

endpackage

`default_nettype wire

// File: rtl/circular_double_ended_queue.sv
// Top level of the circular double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of DEPTH signed 32-bit words held in a circular
// single-port memory with head and tail pointers and an entry count. Each
// input transfer carries one operation (push/pop/peek at front or back) and
// yields exactly one result transfer with the popped or peeked word, a
// status code and the occupancy after the operation. One item is in work
// at a time. The input transfer captures the item, the next cycle runs the
// single memory access with registered read data, and the load state then
// fills the result register once that register is free. The next input
// transfer is accepted only after the load, so a new item is never taken
// before the last one is through. While a result waits in the output
// register the next item still executes, but its load, and with it the
// input, stalls until the waiting result is transferred. The memory needs
// no clearing after reset; only written slots are ever read.
module circular_double_ended_queue
    import cdq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic        [2:0]  s_func,
    input  wire logic signed [31:0] s_data_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_data_out,
    output logic        [1:0]       m_status,
    output logic        [7:0]       m_occupancy
);

    cdq_cmd_t  cmd;
    cdq_stat_t stat;

    cdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_func      (s_func),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out),
        .m_status    (m_status),
        .m_occupancy (m_occupancy)
    );

    // Refused operations never carry data
    a_refuse_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL || m_status == ST_EMPTY)
            |-> m_data_out == MOST_NEG)
        else $error("refused operation returned data");

    // An empty refusal reports an empty queue
    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_occupancy == 8'd0)
        else $error("empty status with nonzero occupancy");

    // Only one item is in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer accepted while busy");

endmodule

`default_nettype wire

// File: rtl/cdq_ctrl.sv
// Controller state machine that sequences capture, execute and result load.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl
    import cdq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output cdq_cmd_t       cmd,
    input  wire cdq_stat_t stat
);

    state_t state_reg;
    state_t state_next;

    // Hold the state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through capture, execute and load
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/cdq_datapath.sv
// Datapath: slot memory, head and tail pointers, count and result register.
`timescale 1ns / 1ps
`default_nettype none

module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cdq_cmd_t           cmd,
    output cdq_stat_t               stat,
    input  wire logic        [2:0]  s_func,
    input  wire logic signed [31:0] s_data_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_data_out,
    output logic        [1:0]       m_status,
    output logic        [7:0]       m_occupancy
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Slot memory
    logic signed [31:0] mem [DEPTH];

    logic        [2:0]       func_reg;
    logic signed [31:0]      din_reg;
    logic        [PTR_W-1:0] head_reg, head_next;
    logic        [PTR_W-1:0] tail_reg, tail_next;
    logic        [CNT_W-1:0] count_reg, count_next;
    logic        [1:0]       stat_reg, stat_next;
    logic                    rd_sel_reg, rd_sel_next;
    logic signed [31:0]      rdata_reg;
    logic                    m_valid_reg;
    logic signed [31:0]      data_out_reg;
    logic        [1:0]       status_out_reg;
    logic        [7:0]       occ_out_reg;

    logic                    mem_we;
    logic                    mem_re;
    logic        [PTR_W-1:0] mem_addr;
    logic        [PTR_W-1:0] head_dec, tail_inc;
    logic        [PTR_W-1:0] head_inc, tail_dec;
    logic        [CNT_W+7:0] count_ext;
    logic                    q_empty, q_full, q_last;

    assign head_dec  = (head_reg == '0) ? PTR_LAST : head_reg - 1'b1;
    assign head_inc  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    assign tail_dec  = (tail_reg == '0) ? PTR_LAST : tail_reg - 1'b1;
    assign tail_inc  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
    assign q_empty   = (count_reg == '0);
    assign q_full    = (count_reg == CNT_FULL);
    assign q_last    = (count_reg == CNT_W'(1));
    assign count_ext = {8'd0, count_reg};

    // Capture the incoming transfer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_func;
            din_reg  <= s_data_in;
        end
    end

    // Decode the operation and compute pointer, count and memory access
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        stat_next   = ST_OK;
        rd_sel_next = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = head_reg;
        case (func_reg)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (q_full) begin
                    stat_next = ST_FULL;
                end else begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (q_empty) begin
                        head_next = '0;
                        tail_next = '0;
                        mem_addr  = '0;
                    end else if (func_reg == FN_PUSH_FRONT) begin
                        head_next = head_dec;
                        mem_addr  = head_dec;
                    end else begin
                        tail_next = tail_inc;
                        mem_addr  = tail_inc;
                    end
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
                if (q_empty) begin
                    stat_next = ST_EMPTY;
                end else begin
                    mem_re      = 1'b1;
                    rd_sel_next = 1'b1;
                    if (func_reg == FN_POP_FRONT || func_reg == FN_PEEK_FRONT) begin
                        mem_addr = head_reg;
                    end else begin
                        mem_addr = tail_reg;
                    end
                    if (func_reg == FN_POP_FRONT || func_reg == FN_POP_BACK) begin
                        count_next = count_reg - 1'b1;
                        if (q_last) begin
                            head_next = '0;
                            tail_next = '0;
                        end else if (func_reg == FN_POP_FRONT) begin
                            head_next = head_inc;
                        end else begin
                            tail_next = tail_dec;
                        end
                    end
                end
            end
            default: begin
                stat_next = ST_OK;
            end
        endcase
    end

    // Write and read the slot memory
    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            mem[mem_addr] <= din_reg;
        end
        if (cmd.exec && mem_re) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Update queue state on execute
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Hold the per-item status until the result is loaded
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            stat_reg   <= stat_next;
            rd_sel_reg <= rd_sel_next;
        end
    end

    // Output register: load a result, drop it once transferred
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            data_out_reg   <= rd_sel_reg ? rdata_reg : MOST_NEG;
            status_out_reg <= stat_reg;
            occ_out_reg    <= count_ext[7:0];
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data_out    = data_out_reg;
    assign m_status      = status_out_reg;
    assign m_occupancy   = occ_out_reg;

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the circular double-ended queue.
`timescale 1ns / 1ps

module tb;
    import cdq_pkg::*;

    localparam int DEPTH = 128;

    // Codes outside the operation set; the block treats them as no-ops
    localparam logic [2:0] FN_SPARE_6 = 3'd6;
    localparam logic [2:0] FN_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic        [1:0]  status;
        logic        [7:0]  occupancy;
    } deque_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic        [2:0]  s_func;
    logic signed [31:0] s_data_in;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_data_out;
    logic        [1:0]  m_status;
    logic        [7:0]  m_occupancy;

    // Shadow copy of the queue contents and pointers
    logic signed [31:0] slot_mem [DEPTH];
    int                 head_idx;
    int                 tail_idx;
    int                 fill_count;

    deque_result_t      pending_results[$];

    int src_idle_pct;
    int dst_idle_pct;
    int stall_request;
    int mismatches;
    int items_sent;
    int results_seen;
    int full_refusals;
    int empty_refusals;
    int peak_fill;

    circular_double_ended_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_data_in  (s_data_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (m_data_out),
        .m_status   (m_status),
        .m_occupancy(m_occupancy)
    );

    // Generate clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bound the run
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Apply one operation to the shadow queue and return its result
    function automatic deque_result_t predict_deque(input logic [2:0] fn,
                                                    input logic signed [31:0] word);
        deque_result_t res;
        bit            front;
        res.data_out = MOST_NEG;
        res.status   = ST_OK;
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (fill_count >= DEPTH) begin
                    res.status = ST_FULL;
                    full_refusals++;
                end else begin
                    if (fill_count == 0) begin
                        head_idx = 0;
                        tail_idx = 0;
                    end else if (fn == FN_PUSH_FRONT) begin
                        head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    end else begin
                        tail_idx = (tail_idx + 1) % DEPTH;
                    end
                    slot_mem[(fn == FN_PUSH_FRONT) ? head_idx : tail_idx] = word;
                    fill_count++;
                    if (fill_count > peak_fill) peak_fill = fill_count;
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
                if (fill_count == 0) begin
                    res.status = ST_EMPTY;
                    empty_refusals++;
                end else begin
                    front = (fn == FN_POP_FRONT) || (fn == FN_PEEK_FRONT);
                    res.data_out = slot_mem[front ? head_idx : tail_idx];
                    if (fn == FN_POP_FRONT || fn == FN_POP_BACK) begin
                        // Last word out puts both pointers back at slot 0
                        if (fill_count == 1) begin
                            head_idx = 0;
                            tail_idx = 0;
                        end else if (front) begin
                            head_idx = (head_idx + 1) % DEPTH;
                        end else begin
                            tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
                        end
                        fill_count--;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = 8'(fill_count);
        return res;
    endfunction

    // Pick a data word, weighted toward the extremes
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fff_ffff;
            1:       return MOST_NEG;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one operation and hold it until the transfer happens
    task automatic issue_op(input logic [2:0] fn, input logic signed [31:0] word);
        deque_result_t want_res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= fn;
        s_data_in <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want_res = predict_deque(fn, word);
        pending_results = {pending_results, want_res};
        items_sent++;
    endtask

    // Drive result-side ready, with an optional long hold-off
    initial begin : ready_gen
        int hold;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_request > 0) begin
                hold = stall_request;
                stall_request = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    // Check each result transfer against the oldest prediction
    always @(posedge aclk) begin : result_check
        deque_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: data %0d status %0d occ %0d",
                             $realtime, m_data_out, m_status, m_occupancy);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_data_out !== want.data_out || m_status !== want.status ||
                    m_occupancy !== want.occupancy) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] exp data/status/occ %0d/%0d/%0d got %0d/%0d/%0d",
                                 $realtime, want.data_out, want.status, want.occupancy,
                                 m_data_out, m_status, m_occupancy);
                end
            end
        end
    end

    // Pops and peeks on an empty queue, plus the spare codes
    task automatic test_empty_refusals();
        issue_op(FN_POP_FRONT, pick_word());
        issue_op(FN_POP_BACK, pick_word());
        issue_op(FN_PEEK_FRONT, pick_word());
        issue_op(FN_PEEK_BACK, pick_word());
        issue_op(FN_SPARE_6, pick_word());
        issue_op(FN_SPARE_7, pick_word());
    endtask

    // Every operation on a small queue, ending empty again
    task automatic test_basic_ops();
        issue_op(FN_PUSH_FRONT, 32'sh7fff_ffff);
        issue_op(FN_PUSH_BACK, MOST_NEG);
        issue_op(FN_PUSH_FRONT, 32'sh0000_0000);
        issue_op(FN_PUSH_BACK, -32'sd1);
        issue_op(FN_PEEK_FRONT, pick_word());
        issue_op(FN_PEEK_BACK, pick_word());
        issue_op(FN_SPARE_6, pick_word());
        issue_op(FN_POP_FRONT, pick_word());
        issue_op(FN_POP_BACK, pick_word());
        issue_op(FN_POP_FRONT, pick_word());
        issue_op(FN_POP_BACK, pick_word());
        issue_op(FN_PUSH_BACK, 32'sh1234_5678);
        issue_op(FN_POP_FRONT, pick_word());
    endtask

    // Fill to capacity, get refused, then drain past empty
    task automatic test_fill_drain();
        while (fill_count < DEPTH)
            issue_op($urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT, pick_word());
        issue_op(FN_PUSH_FRONT, pick_word());
        issue_op(FN_PUSH_BACK, pick_word());
        issue_op(FN_PEEK_FRONT, pick_word());
        issue_op(FN_SPARE_7, pick_word());
        while (fill_count > 0)
            issue_op($urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT, pick_word());
        issue_op(FN_POP_BACK, pick_word());
        issue_op(FN_PEEK_BACK, pick_word());
    endtask

    // Random operations in bursts that push occupancy up or down
    task automatic run_random_phase(input int n_items);
        int          burst_left;
        int          push_pct;
        int          r;
        logic [2:0]  fn;
        burst_left = 0;
        push_pct   = 50;
        repeat (n_items) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(32, 200);
                case ($urandom_range(0, 2))
                    0:       push_pct = 75;
                    1:       push_pct = 25;
                    default: push_pct = 50;
                endcase
            end
            burst_left--;
            r = $urandom_range(0, 99);
            if (r < 3)
                fn = $urandom_range(0, 1) ? FN_SPARE_7 : FN_SPARE_6;
            else if (r < push_pct)
                fn = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
            else if ($urandom_range(0, 9) < 7)
                fn = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
            else
                fn = $urandom_range(0, 1) ? FN_PEEK_BACK : FN_PEEK_FRONT;
            issue_op(fn, pick_word());
        end
    endtask

    // Hold off the result side while the sender keeps offering
    task automatic test_backpressure();
        stall_request = 400;
        repeat (40)
            issue_op(3'($urandom_range(0, 5)), pick_word());
    endtask

    // Release the input and wait for every result to land
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_func        <= FN_PUSH_FRONT;
        s_data_in     <= '0;
        head_idx       = 0;
        tail_idx       = 0;
        fill_count     = 0;
        stall_request  = 0;
        mismatches     = 0;
        items_sent     = 0;
        results_seen   = 0;
        full_refusals  = 0;
        empty_refusals = 0;
        peak_fill      = 0;
        src_idle_pct   = 7;
        dst_idle_pct   = 83;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_refusals();
        test_basic_ops();
        test_fill_drain();
        run_random_phase(350);

        src_idle_pct = 83;
        dst_idle_pct = 7;
        test_backpressure();
        run_random_phase(350);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_random_phase(350);
        test_fill_drain();

        wait_drained();
        $display("Ran %0d operations, checked %0d results, peak occupancy %0d.",
                 items_sent, results_seen, peak_fill);
        $display("Saw %0d full refusals, %0d empty refusals, %0d mismatches.",
                 full_refusals, empty_refusals, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: circular_double_ended_queue.f
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_datapath.sv
rtl/circular_double_ended_queue.sv
verif/tb.sv
